// ----- sv/dsi_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the depth sorter.
package dsi_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TAG_BITS_DEF    = 8;

    localparam int COORD_W    = 32;
    localparam int KEY_W      = 32;
    localparam int OFS_W      = 30;
    localparam int OUT_TAG_W  = 8;
    localparam int IN_TAG_W   = 8;
    localparam int SQ_W       = 64;
    localparam int ACC_W      = 66;
    localparam int ROOT_W     = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W  = 104;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EYE_X         = 3'd0,
        CFG_EYE_Y         = 3'd1,
        CFG_EYE_Z         = 3'd2,
        CFG_GROUND_OFFSET = 3'd3,
        CFG_MAP_OFFSET    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic  capture;
        logic  set_ovf;
        logic  diff;
        logic  mul_en;
        axis_t mul_sel;
        logic  acc_load;
        logic  acc_add;
        logic  sqrt_start;
        logic  key_load;
        logic  scan_init;
        logic  rd_scan;
        logic  rd_scan_next;
        logic  wr_new;
        logic  wr_shift;
        logic  drain_init;
        logic  rd_drain;
        logic  out_load_entry;
        logic  out_load_empty;
        logic  drain_done;
    } dsi_cmd_t;

    typedef struct packed {
        logic full;
        logic sqrt_done;
        logic p_zero;
        logic p_one;
        logic key_ge;
        logic cnt_zero;
        logic out_take;
        logic out_last;
    } dsi_sts_t;

endpackage

// ----- sv/depth_sort_insert_unit.sv -----
// Top level of the painter's-order depth sorter: stream ports, config port, controller and datapath.
// Insert: each stored entry with a smaller key shifts up one place; the 32-step square root dominates.
// Drain: table read, load and hand over per result; the next read waits until the sink takes the result.
// One item is worked at a time; the input stays not ready until the item is finished.
// aresetn is synchronous, active low: clears config registers, entry count and overflow flag.
// Table contents are not cleared; only entries below the entry count are ever read.
module depth_sort_insert_unit #(
    parameter int MAX_ENTRIES = dsi_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = dsi_pkg::TAG_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dsi_pkg::S_TDATA_W-1:0]  s_tdata,  // obj_x, obj_y, obj_z, obj_tag
    input  logic [dsi_pkg::S_TUSER_W-1:0]  s_tuser,  // mode, is_map
    // result item channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsi_pkg::M_TDATA_W-1:0]  m_tdata,  // out_tag, out_key
    output logic                           m_tlast,
    output logic [dsi_pkg::M_TUSER_W-1:0]  m_tuser,  // empty_res, overflow
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [dsi_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dsi_pkg::dsi_cmd_t cmd;
    dsi_pkg::dsi_sts_t sts;

    logic [dsi_pkg::OUT_TAG_W-1:0] out_tag;
    logic [dsi_pkg::KEY_W-1:0]     out_key;
    logic                          out_empty;
    logic                          out_overflow;

    // Controller: accept only in idle; mode bit picks insert or drain.
    dsi_ctrl u_ctrl (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser[0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: unpack the stream word into coordinates and tag.
    dsi_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .clk          (aclk),
        .rstn         (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .obj_x        (s_tdata[31:0]),
        .obj_y        (s_tdata[63:32]),
        .obj_z        (s_tdata[95:64]),
        .obj_tag      (s_tdata[103:96]),
        .is_map       (s_tuser[1]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_tag      (out_tag),
        .out_key      (out_key),
        .out_last     (m_tlast),
        .out_empty    (out_empty),
        .out_overflow (out_overflow)
    );

    // Pack result fields, lowest field in the lowest bits.
    assign m_tdata = {out_key, out_tag};
    assign m_tuser = {out_overflow, out_empty};

endmodule

// ----- sv/dsi_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module dsi_isqrt (
    input  logic                       clk,
    input  logic                       rstn,
    input  logic                       start,
    input  logic [dsi_pkg::SQ_W-1:0]   radicand,
    output logic [dsi_pkg::ROOT_W-1:0] root,
    output logic                       done
);

    localparam logic [dsi_pkg::SQ_W-1:0] BIT_INIT =
        dsi_pkg::SQ_W'(1) << (dsi_pkg::SQ_W - 2);

    logic                     busy_reg;
    logic                     done_reg;
    logic [dsi_pkg::SQ_W-1:0] rem_reg, rem_next;
    logic [dsi_pkg::SQ_W-1:0] res_reg, res_next;
    logic [dsi_pkg::SQ_W-1:0] bit_reg, bit_next;
    logic [dsi_pkg::SQ_W-1:0] trial;

    // res and bit never overlap, so the trial value is a plain OR
    always_comb begin
        trial    = res_reg | bit_reg;
        bit_next = bit_reg >> 2;
        if (rem_reg >= trial) begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) | bit_reg;
        end else begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= BIT_INIT;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign root = res_reg[dsi_pkg::ROOT_W-1:0];
    assign done = done_reg;

endmodule

// ----- sv/dsi_datapath.sv -----
// Datapath: config registers, distance and key arithmetic, sorted table and result register.
module dsi_datapath #(
    parameter int MAX_ENTRIES = dsi_pkg::MAX_ENTRIES_DEF,
    parameter int TAG_BITS    = dsi_pkg::TAG_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rstn,
    input  dsi_pkg::dsi_cmd_t              cmd,
    output dsi_pkg::dsi_sts_t              sts,
    input  logic                           cfg_wr_en,
    input  logic [dsi_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dsi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [dsi_pkg::COORD_W-1:0]    obj_x,
    input  logic [dsi_pkg::COORD_W-1:0]    obj_y,
    input  logic [dsi_pkg::COORD_W-1:0]    obj_z,
    input  logic [dsi_pkg::IN_TAG_W-1:0]   obj_tag,
    input  logic                           is_map,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [dsi_pkg::OUT_TAG_W-1:0]  out_tag,
    output logic [dsi_pkg::KEY_W-1:0]      out_key,
    output logic                           out_last,
    output logic                           out_empty,
    output logic                           out_overflow
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = TAG_BITS + dsi_pkg::KEY_W;
    localparam int SUM_W = dsi_pkg::KEY_W + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    // configuration
    logic [dsi_pkg::COORD_W-1:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [dsi_pkg::OFS_W-1:0]   ground_ofs_reg, map_ofs_reg;

    // captured item
    logic [dsi_pkg::COORD_W-1:0] obj_x_reg, obj_y_reg, obj_z_reg;
    logic [TAG_BITS-1:0]         tag_reg;
    logic                        map_reg;

    // distance arithmetic
    logic [dsi_pkg::COORD_W-1:0] ad_x_reg, ad_y_reg, ad_z_reg;
    logic [dsi_pkg::COORD_W-1:0] mul_op;
    logic [dsi_pkg::SQ_W-1:0]    prod_reg;
    logic [dsi_pkg::ACC_W-1:0]   acc_reg;
    logic [dsi_pkg::ROOT_W-1:0]  root;
    logic                        sqrt_done;
    logic [dsi_pkg::KEY_W-1:0]   dist_val;
    logic [SUM_W-1:0]            key_sum;
    logic [dsi_pkg::KEY_W-1:0]   key_reg;

    // table and pointers
    logic [ENT_W-1:0] mem [MAX_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] p_reg;
    logic [CNT_W-1:0] d_reg;
    logic             ovf_flag_reg;
    logic             rd_en;
    logic [CNT_W-1:0] rd_ptr;
    logic             wr_en;
    logic [ENT_W-1:0] wr_data;
    logic             d_last;

    // result register
    logic                          out_valid_reg;
    logic [dsi_pkg::OUT_TAG_W-1:0] out_tag_reg;
    logic [dsi_pkg::KEY_W-1:0]     out_key_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;
    logic                          out_ovf_reg;

    function automatic logic [dsi_pkg::COORD_W-1:0] abs_diff(
        input logic [dsi_pkg::COORD_W-1:0] a,
        input logic [dsi_pkg::COORD_W-1:0] b
    );
        logic [dsi_pkg::COORD_W:0] d;
        logic [dsi_pkg::COORD_W:0] m;
        d = {a[dsi_pkg::COORD_W-1], a} - {b[dsi_pkg::COORD_W-1], b};
        m = d[dsi_pkg::COORD_W] ? (~d + 1'b1) : d;
        // magnitude of two 32-bit signed values never exceeds 2^32-1
        return m[dsi_pkg::COORD_W-1:0];
    endfunction

    always_ff @(posedge clk) begin
        if (!rstn) begin
            eye_x_reg      <= '0;
            eye_y_reg      <= '0;
            eye_z_reg      <= '0;
            ground_ofs_reg <= '0;
            map_ofs_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dsi_pkg::CFG_EYE_X:         eye_x_reg <= cfg_wdata;
                dsi_pkg::CFG_EYE_Y:         eye_y_reg <= cfg_wdata;
                dsi_pkg::CFG_EYE_Z:         eye_z_reg <= cfg_wdata;
                dsi_pkg::CFG_GROUND_OFFSET: ground_ofs_reg <= cfg_wdata[dsi_pkg::OFS_W-1:0];
                dsi_pkg::CFG_MAP_OFFSET:    map_ofs_reg <= cfg_wdata[dsi_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            dsi_pkg::AXIS_X: mul_op = ad_x_reg;
            dsi_pkg::AXIS_Y: mul_op = ad_y_reg;
            dsi_pkg::AXIS_Z: mul_op = ad_z_reg;
            default:         mul_op = '0;
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            obj_x_reg <= obj_x;
            obj_y_reg <= obj_y;
            obj_z_reg <= obj_z;
            tag_reg   <= TAG_BITS'(obj_tag);
            map_reg   <= is_map;
        end
        if (cmd.diff) begin
            ad_x_reg <= abs_diff(obj_x_reg, eye_x_reg);
            ad_y_reg <= abs_diff(obj_y_reg, eye_y_reg);
            ad_z_reg <= abs_diff(obj_z_reg, eye_z_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_op * mul_op;
        end
        if (cmd.acc_load) begin
            acc_reg <= dsi_pkg::ACC_W'(prod_reg);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + dsi_pkg::ACC_W'(prod_reg);
        end
        if (cmd.key_load) begin
            key_reg <= (|key_sum[SUM_W-1:dsi_pkg::KEY_W]) ? '1 : key_sum[dsi_pkg::KEY_W-1:0];
        end
    end

    dsi_isqrt u_isqrt (
        .clk      (clk),
        .rstn     (rstn),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg[dsi_pkg::SQ_W-1:0]),
        .root     (root),
        .done     (sqrt_done)
    );

    // a sum of squares at or above 2^64 saturates the distance
    always_comb begin
        dist_val = (|acc_reg[dsi_pkg::ACC_W-1:dsi_pkg::SQ_W]) ? '1 : root;
        key_sum  = SUM_W'(dist_val)
                 + ((obj_z_reg == '0) ? SUM_W'(ground_ofs_reg) : '0)
                 + (map_reg ? SUM_W'(map_ofs_reg) : '0);
    end

    // table ports: one write, one registered read
    always_comb begin
        rd_en = cmd.rd_scan | cmd.rd_scan_next | cmd.rd_drain;
        if (cmd.rd_drain) begin
            rd_ptr = d_reg;
        end else if (cmd.rd_scan_next) begin
            rd_ptr = p_reg - CNT_W'(2);
        end else begin
            rd_ptr = p_reg - CNT_W'(1);
        end
        wr_en   = cmd.wr_new | cmd.wr_shift;
        wr_data = cmd.wr_new ? {tag_reg, key_reg} : rd_data_reg;
        d_last  = (d_reg == count_reg - CNT_W'(1));
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[p_reg[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg    <= '0;
            ovf_flag_reg <= 1'b0;
            p_reg        <= '0;
            d_reg        <= '0;
        end else begin
            if (cmd.wr_new) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.drain_done) begin
                count_reg <= '0;
            end
            if (cmd.set_ovf) begin
                ovf_flag_reg <= 1'b1;
            end else if (cmd.drain_done) begin
                ovf_flag_reg <= 1'b0;
            end
            if (cmd.scan_init) begin
                p_reg <= count_reg;
            end else if (cmd.wr_shift) begin
                p_reg <= p_reg - CNT_W'(1);
            end
            if (cmd.drain_init) begin
                d_reg <= '0;
            end else if (cmd.out_load_entry) begin
                d_reg <= d_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load_entry || cmd.out_load_empty) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.drain_init) begin
            out_ovf_reg <= ovf_flag_reg;
        end
        if (cmd.out_load_entry) begin
            out_tag_reg   <= dsi_pkg::OUT_TAG_W'(rd_data_reg[ENT_W-1:dsi_pkg::KEY_W]);
            out_key_reg   <= rd_data_reg[dsi_pkg::KEY_W-1:0];
            out_last_reg  <= d_last;
            out_empty_reg <= 1'b0;
        end else if (cmd.out_load_empty) begin
            out_tag_reg   <= '0;
            out_key_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    always_comb begin
        sts.full      = (count_reg == CNT_MAX);
        sts.sqrt_done = sqrt_done;
        sts.p_zero    = (p_reg == '0);
        sts.p_one     = (p_reg == CNT_W'(1));
        sts.key_ge    = (rd_data_reg[dsi_pkg::KEY_W-1:0] >= key_reg);
        sts.cnt_zero  = (count_reg == '0);
        sts.out_take  = out_valid_reg & out_ready;
        sts.out_last  = out_last_reg;
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_key      = out_key_reg;
    assign out_last     = out_last_reg;
    assign out_empty    = out_empty_reg;
    assign out_overflow = out_ovf_reg;

endmodule

// ----- sv/dsi_ctrl.sv -----
// Controller state machine sequencing insert and drain through the datapath.
module dsi_ctrl (
    input  logic              clk,
    input  logic              rstn,
    input  logic              in_valid,
    input  logic              in_mode,
    output logic              in_ready,
    input  dsi_pkg::dsi_sts_t sts,
    output dsi_pkg::dsi_cmd_t cmd
);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_DIFF      = 14'b00000000000010,
        ST_SQ_X      = 14'b00000000000100,
        ST_SQ_Y      = 14'b00000000001000,
        ST_SQ_Z      = 14'b00000000010000,
        ST_SQ_ACC    = 14'b00000000100000,
        ST_SQRT_GO   = 14'b00000001000000,
        ST_SQRT_WAIT = 14'b00000010000000,
        ST_KEY       = 14'b00000100000000,
        ST_INS_START = 14'b00001000000000,
        ST_INS_CMP   = 14'b00010000000000,
        ST_DR_RD     = 14'b00100000000000,
        ST_DR_LD     = 14'b01000000000000,
        ST_DR_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_mode) begin
                        cmd.drain_init = 1'b1;
                        state_next     = ST_DR_RD;
                    end else if (sts.full) begin
                        cmd.set_ovf = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsi_pkg::AXIS_X;
                state_next  = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = dsi_pkg::AXIS_Y;
                cmd.acc_load = 1'b1;
                state_next   = ST_SQ_Z;
            end
            ST_SQ_Z: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dsi_pkg::AXIS_Z;
                cmd.acc_add = 1'b1;
                state_next  = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_SQRT_GO;
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sts.sqrt_done) begin
                    state_next = ST_KEY;
                end
            end
            ST_KEY: begin
                cmd.key_load  = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = ST_INS_START;
            end
            ST_INS_START: begin
                if (sts.p_zero) begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (sts.key_ge) begin
                    cmd.wr_new = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.wr_shift = 1'b1;
                    if (sts.p_one) begin
                        state_next = ST_INS_START;
                    end else begin
                        cmd.rd_scan_next = 1'b1;
                    end
                end
            end
            ST_DR_RD: begin
                if (sts.cnt_zero) begin
                    cmd.out_load_empty = 1'b1;
                    state_next         = ST_DR_OUT;
                end else begin
                    cmd.rd_drain = 1'b1;
                    state_next   = ST_DR_LD;
                end
            end
            ST_DR_LD: begin
                cmd.out_load_entry = 1'b1;
                state_next         = ST_DR_OUT;
            end
            ST_DR_OUT: begin
                if (sts.out_take) begin
                    if (sts.out_last) begin
                        cmd.drain_done = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.rd_drain = 1'b1;
                        state_next   = ST_DR_LD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the painter's-order depth sorter: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module tb;

    // Item kind carried in the low bit of s_tuser.
    typedef enum bit {
        MODE_INSERT = 1'b0,
        MODE_DRAIN  = 1'b1
    } op_mode_t;

    localparam logic [dsi_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam logic [dsi_pkg::COORD_W-1:0]    COORD_MIN      = 32'h8000_0000;
    localparam logic [dsi_pkg::COORD_W-1:0]    COORD_MAX      = 32'h7FFF_FFFF;
    localparam logic [dsi_pkg::CFG_DATA_W-1:0] ALL_ONES       = 32'hFFFF_FFFF;
    localparam int PHASE_ITEMS      = 76;
    localparam int SETTLE_CYCLES    = 200;  // outlasts the longest insert
    localparam int SINK_HOLD_CYCLES = 400;

    // Predicts the painter's order: keeps its own copy of the depth table and config.
    class depth_order_scoreboard;
        typedef struct packed {
            logic [dsi_pkg::TAG_BITS_DEF-1:0] tag;
            logic [dsi_pkg::KEY_W-1:0]        key;
        } depth_entry_t;

        typedef struct packed {
            logic [dsi_pkg::OUT_TAG_W-1:0] tag;
            logic [dsi_pkg::KEY_W-1:0]     key;
            logic                          last;
            logic                          empty;
            logic                          ovf;
        } drain_result_t;

        logic [dsi_pkg::COORD_W-1:0] eye_x, eye_y, eye_z;
        logic [dsi_pkg::OFS_W-1:0]   ground_ofs, map_ofs;
        bit                          ovf_flag;
        depth_entry_t                sorted_q[$];
        drain_result_t               pending_results[$];
        int mismatches, checked, drains, dropped, saturated;

        function new();
            eye_x = '0;
            eye_y = '0;
            eye_z = '0;
            ground_ofs = '0;
            map_ofs = '0;
            ovf_flag = 1'b0;
        endfunction

        function void set_reg(logic [dsi_pkg::CFG_ADDR_W-1:0] idx,
                              logic [dsi_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                dsi_pkg::CFG_EYE_X:         eye_x = val;
                dsi_pkg::CFG_EYE_Y:         eye_y = val;
                dsi_pkg::CFG_EYE_Z:         eye_z = val;
                dsi_pkg::CFG_GROUND_OFFSET: ground_ofs = val[dsi_pkg::OFS_W-1:0];
                dsi_pkg::CFG_MAP_OFFSET:    map_ofs = val[dsi_pkg::OFS_W-1:0];
                default: ;  // unmapped index: no effect
            endcase
        endfunction

        // Floor of the Euclidean distance to the eye plus offsets, saturated to 32 bits.
        function logic [dsi_pkg::KEY_W-1:0] depth_key(logic [dsi_pkg::COORD_W-1:0] x, y, z,
                                                      bit is_map);
            logic [32:0] dx, dy, dz;
            logic [65:0] sumsq;
            logic [31:0] root, trial;
            logic [63:0] trial_sq;
            logic [33:0] total;
            dx = {x[31], x} - {eye_x[31], eye_x};
            dy = {y[31], y} - {eye_y[31], eye_y};
            dz = {z[31], z} - {eye_z[31], eye_z};
            dx = dx[32] ? -dx : dx;
            dy = dy[32] ? -dy : dy;
            dz = dz[32] ? -dz : dz;
            sumsq = {33'd0, dx} * {33'd0, dx} + {33'd0, dy} * {33'd0, dy}
                  + {33'd0, dz} * {33'd0, dz};
            if (sumsq[65:64] != 2'b00) begin
                root = '1;
            end else begin
                // bit-by-bit root: keep each bit whose trial square still fits
                root = '0;
                for (int b = 31; b >= 0; b--) begin
                    trial = root | (32'd1 << b);
                    trial_sq = {32'd0, trial} * {32'd0, trial};
                    if (trial_sq <= sumsq[63:0])
                        root = trial;
                end
            end
            total = {2'b00, root}
                  + ((z == '0) ? {4'd0, ground_ofs} : 34'd0)
                  + (is_map ? {4'd0, map_ofs} : 34'd0);
            return (total[33:32] != 2'b00) ? '1 : total[31:0];
        endfunction

        function void note_item(op_mode_t mode, logic [dsi_pkg::COORD_W-1:0] x, y, z,
                                logic [dsi_pkg::IN_TAG_W-1:0] tag, bit is_map);
            depth_entry_t e;
            int pos;
            if (mode == MODE_DRAIN) begin
                drains++;
                if (sorted_q.size() == 0)
                    pending_results.push_back('{'0, '0, 1'b1, 1'b1, ovf_flag});
                else
                    foreach (sorted_q[k])
                        pending_results.push_back('{sorted_q[k].tag, sorted_q[k].key,
                                                    k == sorted_q.size() - 1, 1'b0, ovf_flag});
                sorted_q.delete();
                ovf_flag = 1'b0;
                return;
            end
            if (sorted_q.size() >= dsi_pkg::MAX_ENTRIES_DEF) begin
                ovf_flag = 1'b1;
                dropped++;
                return;
            end
            e.tag = tag;
            e.key = depth_key(x, y, z, is_map);
            if (e.key == '1)
                saturated++;
            // equal keys stay ahead of the newcomer
            pos = 0;
            while (pos < sorted_q.size() && sorted_q[pos].key >= e.key)
                pos++;
            sorted_q.insert(pos, e);
        endfunction

        function void check_result(logic [dsi_pkg::OUT_TAG_W-1:0] tag,
                                   logic [dsi_pkg::KEY_W-1:0] key,
                                   logic last, logic empty, logic ovf);
            drain_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_tag %0d out_key %0d", tag, key);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (tag !== want.tag) begin
                $error("out_tag: expected %0d, got %0d", want.tag, tag);
                mismatches++;
            end
            if (key !== want.key) begin
                $error("out_key: expected %0d, got %0d", want.key, key);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                mismatches++;
            end
            if (empty !== want.empty) begin
                $error("empty_res: expected %0d, got %0d", want.empty, empty);
                mismatches++;
            end
            if (ovf !== want.ovf) begin
                $error("overflow: expected %0d, got %0d", want.ovf, ovf);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [dsi_pkg::S_TDATA_W-1:0]    s_tdata   = '0;  // obj_x, obj_y, obj_z, obj_tag
    logic [dsi_pkg::S_TUSER_W-1:0]    s_tuser   = '0;  // mode, is_map
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [dsi_pkg::M_TDATA_W-1:0]    m_tdata;         // out_tag, out_key
    logic                             m_tlast;
    logic [dsi_pkg::M_TUSER_W-1:0]    m_tuser;         // empty_res, overflow
    logic                             cfg_wr_en = 1'b0;
    logic [dsi_pkg::CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [dsi_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    depth_order_scoreboard sb = new();
    bit no_idle;        // both sides run without gaps while set
    bit sink_hold_req;  // ask the sink for one long hold-off
    int items_sent;

    depth_sort_insert_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Offer one item after a random gap; hold it until the handshake, then log it.
    task automatic send_item(op_mode_t mode, logic [dsi_pkg::COORD_W-1:0] x, y, z,
                             logic [dsi_pkg::IN_TAG_W-1:0] tag, bit is_map);
        int gap;
        @(negedge aclk);
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, z, y, x};
        s_tuser  <= {is_map, bit'(mode)};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_item(mode, x, y, z, tag, is_map);
        items_sent++;
    endtask

    task automatic send_drain();
        send_item(MODE_DRAIN, $urandom(), $urandom(), $urandom(),
                  dsi_pkg::IN_TAG_W'($urandom()), 1'($urandom()));
    endtask

    // Drop valid, wait out every pending result, then let a trailing insert finish.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Drive one register write; the caller lowers the enable after the last one.
    task automatic write_reg(logic [dsi_pkg::CFG_ADDR_W-1:0] idx,
                             logic [dsi_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [dsi_pkg::CFG_DATA_W-1:0] ex, ey, ez, gofs, mofs,
                             bit poke_unused);
        write_reg(dsi_pkg::CFG_EYE_X, ex);
        write_reg(dsi_pkg::CFG_EYE_Y, ey);
        write_reg(dsi_pkg::CFG_EYE_Z, ez);
        write_reg(dsi_pkg::CFG_GROUND_OFFSET, gofs);
        write_reg(dsi_pkg::CFG_MAP_OFFSET, mofs);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, $urandom());
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly near the eye so that keys collide; sometimes extremes or anything at all.
    function automatic logic [dsi_pkg::COORD_W-1:0] pick_coord(
        logic [dsi_pkg::COORD_W-1:0] centre);
        case ($urandom_range(0, 7))
            0, 1: return $urandom();
            2: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    default: return centre;
                endcase
            end
            default: return centre + $urandom_range(0, 16) - 8;
        endcase
    endfunction

    task automatic send_random_insert();
        logic [dsi_pkg::COORD_W-1:0] z;
        z = ($urandom_range(0, 3) == 0) ? '0 : pick_coord(sb.eye_z);
        send_item(MODE_INSERT, pick_coord(sb.eye_x), pick_coord(sb.eye_y), z,
                  dsi_pkg::IN_TAG_W'($urandom()), $urandom_range(0, 5) == 0);
    endtask

    // One frame: a batch of inserts closed by a drain.
    task automatic run_frame(int n_inserts);
        repeat (n_inserts) send_random_insert();
        send_drain();
    endtask

    // Sink: random hold-offs, one long hold when asked, check every accepted result.
    initial begin : sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall = SINK_HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata[7:0], m_tdata[39:8], m_tlast, m_tuser[0], m_tuser[1]);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout: %0d results still expected", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int phase_start;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty drain, coordinate extremes, ground and map, ties.
        send_drain();
        send_item(MODE_INSERT, '0, '0, '0, 8'hFF, 1'b0);
        send_item(MODE_INSERT, COORD_MAX, COORD_MAX, COORD_MAX, 8'h00, 1'b0);
        send_item(MODE_INSERT, COORD_MIN, COORD_MIN, COORD_MIN, 8'h55, 1'b1);
        send_item(MODE_INSERT, '0, '0, '0, 8'hAA, 1'b0);
        send_item(MODE_INSERT, 32'd3, 32'd4, '0, 8'h01, 1'b1);
        send_drain();
        send_drain();

        // Eye at opposite corners, offsets at full scale: saturation and its edge.
        wait_idle();
        configure(COORD_MAX, COORD_MIN, COORD_MAX, ALL_ONES, ALL_ONES, 1'b0);
        send_item(MODE_INSERT, COORD_MIN, COORD_MAX, COORD_MIN, 8'h10, 1'b1);
        send_item(MODE_INSERT, COORD_MIN, COORD_MIN, COORD_MAX, 8'h20, 1'b0);
        send_item(MODE_INSERT, COORD_MAX, COORD_MIN, '0, 8'h30, 1'b1);
        send_item(MODE_INSERT, COORD_MAX, COORD_MIN, '0, 8'h40, 1'b0);
        send_item(MODE_INSERT, COORD_MAX, COORD_MIN, COORD_MAX, 8'h50, 1'b1);
        send_item(MODE_INSERT, COORD_MAX, COORD_MIN + 1, COORD_MAX, 8'h60, 1'b0);
        send_drain();

        // Random frames, one config setting per phase.
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
                1: configure(COORD_MIN, COORD_MIN, COORD_MIN, '0, ALL_ONES, 1'b1);
                2: configure(COORD_MAX, COORD_MAX, COORD_MAX, ALL_ONES, '0, 1'b0);
                3: configure('0, '0, '0, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
                4: configure($urandom(), $urandom(), $urandom(), ALL_ONES, ALL_ONES, 1'b1);
                default: configure($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                                   $urandom_range(0, 2000) - 1000, '0, '0, 1'b0);
            endcase
            no_idle = (phase == 2);
            phase_start = items_sent;
            if (phase == 3) begin
                // Hold the sink mid-drain while inserts keep coming: the block backs up.
                sink_hold_req = 1'b1;
                run_frame(12);
                run_frame(6);
            end
            if (phase == 4)
                run_frame(dsi_pkg::MAX_ENTRIES_DEF + 4);
            while (items_sent - phase_start < PHASE_ITEMS)
                run_frame(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(0, 12));
        end
        no_idle = 1'b0;

        wait_idle();
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        $display("Covered %0d input items, %0d drains, %0d results checked.",
                 items_sent, sb.drains, sb.checked);
        $display("Inserts dropped on a full table: %0d; saturated keys: %0d.",
                 sb.dropped, sb.saturated);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dsi_pkg.sv
sv/dsi_isqrt.sv
sv/dsi_datapath.sv
sv/dsi_ctrl.sv
sv/depth_sort_insert_unit.sv
tb/tb.sv
